### hw/rtl/gmmh_pkg.sv
// shared constants, types and helpers of the group min/max hash accumulator
package gmmh_pkg;

  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_BITS    = 52;
  localparam int unsigned GID_BITS    = 20;
  localparam int unsigned VAL_BITS    = 32;
  localparam int unsigned THR_BITS    = 31;
  localparam int unsigned COUNT_BITS  = 11;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [63:0]           HASH_MULT    = 64'd1099511628211;
  localparam logic [SLOT_BITS-1:0]  HASH_LOW     = HASH_MULT[SLOT_BITS-1:0];
  localparam logic [SLOT_BITS-1:0]  SLOT_LAST    = SLOT_BITS'(TABLE_SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [THR_BITS-1:0]   THRESH_RESET = THR_BITS'(205887);

  localparam logic REG_SPREAD_THRESHOLD = 1'b0;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [VAL_BITS-1:0] mn;
    logic [VAL_BITS-1:0] mx;
  } entry_t;

  localparam int unsigned ENTRY_BITS = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_UPDATE,
    ST_DONE
  } state_e;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

### hw/rtl/gmmh_in_if.sv
// input request channel of the group min/max hash accumulator
interface gmmh_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [31:0]                          cube_index;
  logic [gmmh_pkg::GID_BITS-1:0]        group_id;
  logic signed [gmmh_pkg::VAL_BITS-1:0] sample_value;

  modport source (output valid, cube_index, group_id, sample_value, input ready);
  modport sink   (input valid, cube_index, group_id, sample_value, output ready);
endinterface

### hw/rtl/gmmh_out_if.sv
// result channel of the group min/max hash accumulator
interface gmmh_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 was_new;
  logic signed [gmmh_pkg::VAL_BITS-1:0] entry_min;
  logic signed [gmmh_pkg::VAL_BITS-1:0] entry_max;
  logic [gmmh_pkg::COUNT_BITS-1:0]      group_count;
  logic [gmmh_pkg::COUNT_BITS-1:0]      wide_group_count;
  logic                                 table_full;

  modport source (output valid, was_new, entry_min, entry_max, group_count,
                  wide_group_count, table_full, input ready);
  modport sink   (input valid, was_new, entry_min, entry_max, group_count,
                  wide_group_count, table_full, output ready);
endinterface

### hw/rtl/gmmh_ram.sv
// generic single write port ram with registered read
module gmmh_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/gmmh_spread_unit.sv
// shared spread compare: exact max minus min against the threshold
module gmmh_spread_unit (
  input  logic [gmmh_pkg::VAL_BITS-1:0] lo_i,
  input  logic [gmmh_pkg::VAL_BITS-1:0] hi_i,
  input  logic [gmmh_pkg::THR_BITS-1:0] thr_i,
  output logic                          reach_o
);

  logic signed [gmmh_pkg::VAL_BITS:0] spread;
  logic signed [gmmh_pkg::VAL_BITS:0] thr_ext;

  assign spread  = {hi_i[gmmh_pkg::VAL_BITS-1], hi_i} - {lo_i[gmmh_pkg::VAL_BITS-1], lo_i};
  assign thr_ext = {2'b00, thr_i};
  assign reach_o = (spread >= thr_ext);

endmodule

### hw/rtl/group_min_max_hash_accumulator_top.sv
// top level of the group min/max hash accumulator
//
//  channel | dir | handshake      | payload
//  in_i    | in  | valid / ready  | cube_index, group_id, sample_value
//  out_o   | out | valid / ready  | was_new, entry_min, entry_max, group_count,
//          |     |                | wide_group_count, table_full
//  apb     | in  | psel / penable | paddr, pwdata, prdata (pready tied high)
//
// each probe of a request passes ST_READ and ST_CHECK, a known key then ST_UPDATE,
// and every request ends in ST_DONE; each probe is one read of the slot ram
// after reset a clearing pass writes all 1024 slots, one per cycle, with in_i not ready
// the result sits in an output register, so a new request is taken while it waits
// a request that finishes while the previous result is still held waits in its last step
module group_min_max_hash_accumulator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gmmh_in_if.sink                         in_i,
  gmmh_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gmmh_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  gmmh_pkg::state_e state_q, state_d;

  logic [gmmh_pkg::SLOT_BITS-1:0]  clr_q, clr_d;
  logic [gmmh_pkg::SLOT_BITS-1:0]  addr_q, addr_d;
  logic [gmmh_pkg::SLOT_BITS-1:0]  probe_q, probe_d;
  logic [gmmh_pkg::KEY_BITS-1:0]   key_q, key_d;
  logic [gmmh_pkg::VAL_BITS-1:0]   samp_q, samp_d;
  logic [gmmh_pkg::VAL_BITS-1:0]   lo_q, lo_d;
  logic [gmmh_pkg::VAL_BITS-1:0]   hi_q, hi_d;
  logic                            before_q, before_d;
  logic                            new_q, new_d;
  logic                            full_q, full_d;
  logic [gmmh_pkg::COUNT_BITS-1:0] stored_q, stored_d;
  logic [gmmh_pkg::COUNT_BITS-1:0] wide_q, wide_d;
  logic [gmmh_pkg::THR_BITS-1:0]   thr_q, thr_d;

  logic                            ov_q, ov_d;
  logic                            o_new_q, o_new_d;
  logic [gmmh_pkg::VAL_BITS-1:0]   o_min_q, o_min_d;
  logic [gmmh_pkg::VAL_BITS-1:0]   o_max_q, o_max_d;
  logic [gmmh_pkg::COUNT_BITS-1:0] o_gc_q, o_gc_d;
  logic [gmmh_pkg::COUNT_BITS-1:0] o_wc_q, o_wc_d;
  logic                            o_full_q, o_full_d;

  logic                            in_ready;
  logic                            in_take;
  logic                            out_free;
  logic [gmmh_pkg::KEY_BITS-1:0]   in_key;
  logic [2*gmmh_pkg::SLOT_BITS-1:0] hash_prod;

  logic                            ram_we;
  logic [gmmh_pkg::SLOT_BITS-1:0]  ram_waddr;
  gmmh_pkg::entry_t                ram_wdata;
  gmmh_pkg::entry_t                ram_rdata;
  logic [gmmh_pkg::ENTRY_BITS-1:0] ram_rbits;

  logic                            slot_hit;
  logic                            slot_empty;
  logic                            samp_below;
  logic                            samp_above;
  logic [gmmh_pkg::VAL_BITS-1:0]   su_lo;
  logic [gmmh_pkg::VAL_BITS-1:0]   su_hi;
  logic                            su_reach;
  logic                            cfg_write;

  assign in_key    = {in_i.cube_index, in_i.group_id};
  assign hash_prod = {gmmh_pkg::SLOT_BITS'(0), in_key[gmmh_pkg::SLOT_BITS-1:0]}
                   * {gmmh_pkg::SLOT_BITS'(0), gmmh_pkg::HASH_LOW};
  assign in_take   = in_i.valid && in_ready;
  assign out_free  = !ov_q || out_o.ready;

  assign ram_rdata  = gmmh_pkg::entry_t'(ram_rbits);
  assign slot_hit   = ram_rdata.valid && (ram_rdata.key == key_q);
  assign slot_empty = !ram_rdata.valid;
  assign samp_below = $signed(samp_q) < $signed(ram_rdata.mn);
  assign samp_above = $signed(samp_q) > $signed(ram_rdata.mx);

  gmmh_ram #(
    .WIDTH (gmmh_pkg::ENTRY_BITS),
    .DEPTH (gmmh_pkg::TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rbits)
  );

  gmmh_spread_unit u_spread (
    .lo_i    (su_lo),
    .hi_i    (su_hi),
    .thr_i   (thr_q),
    .reach_o (su_reach)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gmmh_pkg::ST_CLEAR: begin
        if (clr_q == gmmh_pkg::SLOT_LAST) begin
          state_d = gmmh_pkg::ST_IDLE;
        end
      end
      gmmh_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = gmmh_pkg::ST_READ;
        end
      end
      gmmh_pkg::ST_READ: begin
        state_d = gmmh_pkg::ST_CHECK;
      end
      gmmh_pkg::ST_CHECK: begin
        if (slot_hit) begin
          state_d = gmmh_pkg::ST_UPDATE;
        end else if (slot_empty || (probe_q == gmmh_pkg::SLOT_LAST)) begin
          state_d = gmmh_pkg::ST_DONE;
        end else begin
          state_d = gmmh_pkg::ST_READ;
        end
      end
      gmmh_pkg::ST_UPDATE: begin
        state_d = gmmh_pkg::ST_DONE;
      end
      gmmh_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = gmmh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gmmh_pkg::ST_CLEAR;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    su_lo     = lo_q;
    su_hi     = hi_q;
    case (state_q)
      gmmh_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      gmmh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      gmmh_pkg::ST_CHECK: begin
        if (slot_empty) begin
          su_lo     = samp_q;
          su_hi     = samp_q;
          ram_we    = 1'b1;
          ram_wdata = '{valid: 1'b1, key: key_q, mn: samp_q, mx: samp_q};
        end else begin
          su_lo = ram_rdata.mn;
          su_hi = ram_rdata.mx;
        end
      end
      gmmh_pkg::ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_wdata = '{valid: 1'b1, key: key_q, mn: lo_q, mx: hi_q};
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    clr_d    = clr_q;
    addr_d   = addr_q;
    probe_d  = probe_q;
    key_d    = key_q;
    samp_d   = samp_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    before_d = before_q;
    new_d    = new_q;
    full_d   = full_q;
    stored_d = stored_q;
    wide_d   = wide_q;
    ov_d     = ov_q;
    o_new_d  = o_new_q;
    o_min_d  = o_min_q;
    o_max_d  = o_max_q;
    o_gc_d   = o_gc_q;
    o_wc_d   = o_wc_q;
    o_full_d = o_full_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      gmmh_pkg::ST_CLEAR: begin
        clr_d = clr_q + gmmh_pkg::SLOT_BITS'(1);
      end
      gmmh_pkg::ST_IDLE: begin
        if (in_take) begin
          key_d   = in_key;
          samp_d  = in_i.sample_value;
          addr_d  = hash_prod[gmmh_pkg::SLOT_BITS-1:0];
          probe_d = '0;
        end
      end
      gmmh_pkg::ST_CHECK: begin
        if (slot_hit) begin
          new_d    = 1'b0;
          full_d   = 1'b0;
          before_d = su_reach;
          lo_d     = samp_below ? samp_q : ram_rdata.mn;
          hi_d     = samp_above ? samp_q : ram_rdata.mx;
        end else if (slot_empty) begin
          new_d    = 1'b1;
          full_d   = 1'b0;
          lo_d     = samp_q;
          hi_d     = samp_q;
          stored_d = gmmh_pkg::sat_inc(stored_q);
          if (su_reach) begin
            wide_d = gmmh_pkg::sat_inc(wide_q);
          end
        end else if (probe_q == gmmh_pkg::SLOT_LAST) begin
          new_d  = 1'b0;
          full_d = 1'b1;
          lo_d   = '0;
          hi_d   = '0;
        end else begin
          addr_d  = addr_q + gmmh_pkg::SLOT_BITS'(1);
          probe_d = probe_q + gmmh_pkg::SLOT_BITS'(1);
        end
      end
      gmmh_pkg::ST_UPDATE: begin
        if (!before_q && su_reach) begin
          wide_d = gmmh_pkg::sat_inc(wide_q);
        end
      end
      gmmh_pkg::ST_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_new_d  = new_q;
          o_min_d  = lo_q;
          o_max_d  = hi_q;
          o_gc_d   = stored_q;
          o_wc_d   = wide_q;
          o_full_d = full_q;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration port
  assign cfg_write = psel && penable && pwrite
                  && (paddr[gmmh_pkg::CFG_ADDR_W-1] == gmmh_pkg::REG_SPREAD_THRESHOLD);
  assign thr_d     = cfg_write ? pwdata[gmmh_pkg::THR_BITS-1:0] : thr_q;
  assign prdata    = (paddr[gmmh_pkg::CFG_ADDR_W-1] == gmmh_pkg::REG_SPREAD_THRESHOLD)
                   ? {1'b0, thr_q} : 32'd0;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gmmh_pkg::ST_CLEAR;
      clr_q    <= '0;
      stored_q <= '0;
      wide_q   <= '0;
      thr_q    <= gmmh_pkg::THRESH_RESET;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      stored_q <= stored_d;
      wide_q   <= wide_d;
      thr_q    <= thr_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    probe_q  <= probe_d;
    key_q    <= key_d;
    samp_q   <= samp_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    before_q <= before_d;
    new_q    <= new_d;
    full_q   <= full_d;
    o_new_q  <= o_new_d;
    o_min_q  <= o_min_d;
    o_max_q  <= o_max_d;
    o_gc_q   <= o_gc_d;
    o_wc_q   <= o_wc_d;
    o_full_q <= o_full_d;
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = ov_q;
  assign out_o.was_new          = o_new_q;
  assign out_o.entry_min        = o_min_q;
  assign out_o.entry_max        = o_max_q;
  assign out_o.group_count      = o_gc_q;
  assign out_o.wide_group_count = o_wc_q;
  assign out_o.table_full       = o_full_q;

endmodule

### hw/rtl/gmmh_checker.sv
// port level checks of the group min/max hash accumulator and their bind
module gmmh_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            was_new_i,
  input logic [gmmh_pkg::VAL_BITS-1:0]   entry_min_i,
  input logic [gmmh_pkg::VAL_BITS-1:0]   entry_max_i,
  input logic [gmmh_pkg::COUNT_BITS-1:0] group_count_i,
  input logic [gmmh_pkg::COUNT_BITS-1:0] wide_group_count_i,
  input logic                            table_full_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(entry_min_i)
      && $stable(entry_max_i) && $stable(was_new_i) && $stable(table_full_i)
      && $stable(group_count_i) && $stable(wide_group_count_i))
    else $error("stalled result changed");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after a request");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && table_full_i |-> !was_new_i && (entry_min_i == '0)
      && (entry_max_i == '0))
    else $error("dropped request with payload");

  a_new_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && was_new_i |-> (entry_min_i == entry_max_i) && !table_full_i)
    else $error("new group with a spread");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !table_full_i |-> $signed(entry_min_i) <= $signed(entry_max_i))
    else $error("min above max");

endmodule

bind group_min_max_hash_accumulator_top gmmh_checker u_gmmh_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .was_new_i          (out_o.was_new),
  .entry_min_i        (out_o.entry_min),
  .entry_max_i        (out_o.entry_max),
  .group_count_i      (out_o.group_count),
  .wide_group_count_i (out_o.wide_group_count),
  .table_full_i       (out_o.table_full)
);
